// ----- rtl/fsqs_pkg.sv -----
// ----------------------------------------------------------------------------
// fsqs_pkg
// Shared types, sizes and codes of the fair-share queue scheduler.
// ----------------------------------------------------------------------------
package fsqs_pkg;

	localparam int NUM_QUEUES  = 16;
	localparam int QUEUE_DEPTH = 16;
	localparam int TIME_BITS   = 48;

	localparam int QB = $clog2(NUM_QUEUES);
	localparam int DB = $clog2(QUEUE_DEPTH);
	localparam int CB = $clog2(QUEUE_DEPTH + 1);
	localparam int AB = QB + DB;
	localparam int PB = $clog2(NUM_QUEUES * QUEUE_DEPTH + 1);
	localparam int EW = TIME_BITS + 16;

	typedef logic [TIME_BITS-1:0] time_t;

	localparam time_t       TIME_MAX     = '1;
	localparam logic [47:0] WINDOW_RESET = 48'd1000000;

	// operation codes
	localparam logic [1:0] MODE_ENQ  = 2'd0;
	localparam logic [1:0] MODE_DISP = 2'd1;
	localparam logic [1:0] MODE_DONE = 2'd2;
	localparam logic [1:0] MODE_NOP  = 2'd3;

	// result codes
	localparam logic [2:0] RS_ENQUEUED   = 3'd0;
	localparam logic [2:0] RS_FULL       = 3'd1;
	localparam logic [2:0] RS_DISPATCHED = 3'd2;
	localparam logic [2:0] RS_NONE_RUN   = 3'd3;
	localparam logic [2:0] RS_TRIM_EMPTY = 3'd4;
	localparam logic [2:0] RS_BUSY       = 3'd5;
	localparam logic [2:0] RS_COMPLETED  = 3'd6;
	localparam logic [2:0] RS_NO_PEND    = 3'd7;

	// per-queue state codes
	localparam logic [1:0] QS_ABSENT   = 2'd0;
	localparam logic [1:0] QS_RUNNABLE = 2'd1;
	localparam logic [1:0] QS_IDLE     = 2'd2;
	localparam logic [1:0] QS_RUNNING  = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE, S_DEC, S_SCAN, S_EVICT, S_HRD, S_HCK, S_CMP2, S_CMP3,
		S_OVL, S_ORD, S_OCK, S_FIN, S_OUT
	} fsm_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [3:0]  queue_id;
		logic        droppable;
		logic [15:0] action_tag;
		logic [47:0] now;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  out_queue;
		logic [15:0] out_tag;
		logic [4:0]  dropped_count;
		logic        overloaded;
		logic [8:0]  pending_total;
	} out_item_t;

	function automatic logic [QB-1:0] qid_mod(logic [3:0] id);
		logic [QB+4:0] v;
		v = (QB+5)'(id);
		for (int k = 0; k < 8; k++)
			if (v >= (QB+5)'(NUM_QUEUES)) v = v - (QB+5)'(NUM_QUEUES);
		return v[QB-1:0];
	endfunction

	function automatic logic [DB-1:0] head_inc(logic [DB-1:0] h);
		return (h == DB'(QUEUE_DEPTH - 1)) ? '0 : h + 1'b1;
	endfunction

	function automatic logic [DB-1:0] slot_of(logic [DB-1:0] h, logic [CB-1:0] c);
		logic [CB:0] s;
		s = (CB+1)'(h) + (CB+1)'(c);
		if (s >= (CB+1)'(QUEUE_DEPTH)) s = s - (CB+1)'(QUEUE_DEPTH);
		return s[DB-1:0];
	endfunction

	// head entry older than the window
	function automatic logic is_over(time_t now, time_t t, time_t w);
		return {1'b0, now} > ({1'b0, t} + {1'b0, w});
	endfunction

endpackage

// ----- rtl/fsqs_front.sv -----
// ----------------------------------------------------------------------------
// fsqs_front
// Two-entry input queue between the item port and the sequencer.
// ----------------------------------------------------------------------------
module fsqs_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  fsqs_pkg::in_item_t in_data,
	output logic               item_valid,
	input  logic               item_pop,
	output fsqs_pkg::in_item_t item
);
	import fsqs_pkg::*;

	in_item_t   buf_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign in_stall   = (cnt_q == 2'd2);
	assign push       = in_valid && !in_stall;
	assign item_valid = (cnt_q != 2'd0);
	assign pop        = item_pop && item_valid;
	assign item       = buf_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) buf_q[wr_ptr_q] <= in_data;
	end

endmodule

// ----- rtl/fsqs_back.sv -----
// ----------------------------------------------------------------------------
// fsqs_back
// Sequencer: queue state, entry memory, scans, trimming and overload check.
// ----------------------------------------------------------------------------
module fsqs_back (
	input  logic                clk,
	input  logic                arst_n,
	input  fsqs_pkg::time_t     window,
	input  logic                item_valid,
	input  fsqs_pkg::in_item_t  item,
	output logic                item_pop,
	input  logic                slot_free,
	output logic                res_valid,
	output fsqs_pkg::out_item_t res
);
	import fsqs_pkg::*;

	fsm_t state_q, state_d;

	// per-queue state
	logic [DB-1:0] head_q [NUM_QUEUES];
	logic [DB-1:0] head_d [NUM_QUEUES];
	logic [CB-1:0] cnt_q  [NUM_QUEUES];
	logic [CB-1:0] cnt_d  [NUM_QUEUES];
	time_t         svc_q  [NUM_QUEUES];
	time_t         svc_d  [NUM_QUEUES];
	time_t         last_q [NUM_QUEUES];
	time_t         last_d [NUM_QUEUES];
	logic [1:0]    qst_q  [NUM_QUEUES];
	logic [1:0]    qst_d  [NUM_QUEUES];
	logic          drp_q  [NUM_QUEUES];
	logic          drp_d  [NUM_QUEUES];
	logic [7:0]    iord_q [NUM_QUEUES];
	logic [7:0]    iord_d [NUM_QUEUES];

	// global state
	time_t         maxs_q, maxs_d, disp_q, disp_d, floor_q, floor_d;
	logic          ovl_q, ovl_d, runv_q, runv_d;
	logic [QB-1:0] runq_q, runq_d;
	logic [PB-1:0] pend_q, pend_d;

	// sequencer work registers
	in_item_t      it_q, it_d;
	logic [QB-1:0] scan_q, scan_d, cur_q, cur_d, ibest_q, ibest_d, rbest_q, rbest_d;
	logic [7:0]    iobest_q, iobest_d;
	time_t         rsvc_q, rsvc_d, dur_q, dur_d, sum_q, sum_d;
	logic          ifound_q, ifound_d, rfound_q, rfound_d;
	logic          ov_all_q, ov_all_d, any_q, any_d, fin_done_q, fin_done_d;
	logic [CB-1:0] drop_q, drop_d;
	logic [2:0]    rs_st_q, rs_st_d;
	logic [QB-1:0] rs_qu_q, rs_qu_d;
	logic [15:0]   rs_tag_q, rs_tag_d;

	// entry memory
	logic [EW-1:0] mem [1 << AB];
	logic [EW-1:0] rd_q;
	logic [AB-1:0] raddr, waddr;
	logic [EW-1:0] wdata;
	logic          mem_we;

	// shared read port into the queue state
	logic [QB-1:0] ix, qid;
	logic [DB-1:0] c_head;
	logic [CB-1:0] c_cnt;
	time_t         c_svc, c_last, now_t, rd_time;
	logic [1:0]    c_qst;
	logic [7:0]    c_iord;
	logic          o_hit;
	logic [TIME_BITS:0] wsum;
	time_t         s_val;

	assign qid     = qid_mod(it_q.queue_id);
	assign now_t   = time_t'(it_q.now);
	assign rd_time = rd_q[EW-1:16];

	always_comb begin
		unique case (state_q)
			S_DEC:        ix = qid;
			S_SCAN:       ix = scan_q;
			S_EVICT:      ix = ibest_q;
			S_ORD, S_OCK: ix = ov_all_q ? scan_q : cur_q;
			default:      ix = cur_q;
		endcase
	end

	assign c_head = head_q[ix];
	assign c_cnt  = cnt_q[ix];
	assign c_svc  = svc_q[ix];
	assign c_last = last_q[ix];
	assign c_qst  = qst_q[ix];
	assign c_iord = iord_q[ix];
	assign raddr  = {ix, c_head};
	assign o_hit  = (c_cnt != '0) && is_over(now_t, rd_time, window);

	always_comb begin
		state_d = state_q;
		head_d = head_q; cnt_d = cnt_q; svc_d = svc_q; last_d = last_q;
		qst_d = qst_q; drp_d = drp_q; iord_d = iord_q;
		maxs_d = maxs_q; disp_d = disp_q; floor_d = floor_q;
		ovl_d = ovl_q; runv_d = runv_q; runq_d = runq_q; pend_d = pend_q;
		it_d = it_q; scan_d = scan_q; cur_d = cur_q; ibest_d = ibest_q;
		rbest_d = rbest_q; iobest_d = iobest_q; rsvc_d = rsvc_q;
		dur_d = dur_q; sum_d = sum_q; ifound_d = ifound_q; rfound_d = rfound_q;
		ov_all_d = ov_all_q; any_d = any_q; fin_done_d = fin_done_q;
		drop_d = drop_q; rs_st_d = rs_st_q; rs_qu_d = rs_qu_q; rs_tag_d = rs_tag_q;
		item_pop = 1'b0;
		res_valid = 1'b0;
		mem_we = 1'b0;
		waddr = {qid, slot_of(c_head, c_cnt)};
		wdata = {now_t, it_q.action_tag};
		wsum = '0;
		s_val = '0;

		unique case (state_q)
			S_IDLE: begin
				if (item_valid && slot_free) begin
					item_pop = 1'b1;
					it_d = item;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				rs_qu_d = '0; rs_tag_d = '0; drop_d = '0;
				state_d = S_OUT;
				if (it_q.mode == MODE_ENQ) begin
					rs_qu_d = qid;
					if (c_cnt >= CB'(QUEUE_DEPTH)) begin
						rs_st_d = RS_FULL;
					end else begin
						rs_st_d = RS_ENQUEUED;
						mem_we = 1'b1;
						if (c_qst == QS_ABSENT) begin
							qst_d[qid] = QS_RUNNABLE;
							drp_d[qid] = it_q.droppable;
							svc_d[qid] = '0;
							last_d[qid] = TIME_MAX;
							head_d[qid] = '0;
							cnt_d[qid] = CB'(1);
							waddr = {qid, {DB{1'b0}}};
						end else begin
							if (c_qst == QS_IDLE) begin
								for (int i = 0; i < NUM_QUEUES; i++)
									if (QB'(i) != qid && qst_q[i] == QS_IDLE &&
									    iord_q[i] > c_iord)
										iord_d[i] = iord_q[i] - 8'd1;
								iord_d[qid] = '0;
								qst_d[qid] = QS_RUNNABLE;
							end
							cnt_d[qid] = c_cnt + 1'b1;
						end
						pend_d = pend_q + 1'b1;
					end
				end else if (it_q.mode == MODE_DISP) begin
					if (runv_q) begin
						rs_st_d = RS_BUSY;
					end else begin
						scan_d = '0;
						ifound_d = 1'b0;
						rfound_d = 1'b0;
						state_d = S_SCAN;
					end
				end else if (it_q.mode == MODE_DONE && runv_q) begin
					cur_d = runq_q;
					dur_d = (now_t > disp_q) ? now_t - disp_q : '0;
					state_d = S_CMP2;
				end else begin
					rs_st_d = RS_NO_PEND;
				end
			end
			S_SCAN: begin
				// oldest idle queue and least-served runnable queue in one pass
				if (c_qst == QS_IDLE && (!ifound_q || c_iord > iobest_q)) begin
					ifound_d = 1'b1; ibest_d = scan_q; iobest_d = c_iord;
				end
				if (c_qst == QS_RUNNABLE && (!rfound_q || c_svc < rsvc_q)) begin
					rfound_d = 1'b1; rbest_d = scan_q; rsvc_d = c_svc;
				end
				scan_d = scan_q + 1'b1;
				if (scan_q == QB'(NUM_QUEUES - 1)) state_d = S_EVICT;
			end
			S_EVICT: begin
				wsum = {1'b0, c_last} + {1'b0, window};
				if (ifound_q && wsum < {1'b0, now_t}) begin
					for (int i = 0; i < NUM_QUEUES; i++)
						if (QB'(i) != ibest_q && qst_q[i] == QS_IDLE && iord_q[i] > c_iord)
							iord_d[i] = iord_q[i] - 8'd1;
					iord_d[ibest_q] = '0;
					qst_d[ibest_q] = QS_ABSENT;
				end
				if (!rfound_q) begin
					rs_st_d = RS_NONE_RUN;
					state_d = S_OUT;
				end else begin
					cur_d = rbest_q;
					state_d = S_HRD;
				end
			end
			S_HRD: state_d = S_HCK;
			S_HCK: begin
				if (drp_q[cur_q] && o_hit) begin
					head_d[cur_q] = head_inc(c_head);
					cnt_d[cur_q] = c_cnt - 1'b1;
					if (pend_q != '0) pend_d = pend_q - 1'b1;
					drop_d = drop_q + 1'b1;
					state_d = S_HRD;
				end else if (c_cnt == '0) begin
					fin_done_d = 1'b0;
					state_d = S_OVL;
				end else begin
					floor_d = (maxs_q > window) ? maxs_q - window : '0;
					rs_tag_d = rd_q[15:0];
					head_d[cur_q] = head_inc(c_head);
					cnt_d[cur_q] = c_cnt - 1'b1;
					if (pend_q != '0) pend_d = pend_q - 1'b1;
					qst_d[cur_q] = QS_RUNNING;
					runq_d = cur_q;
					runv_d = 1'b1;
					disp_d = now_t;
					rs_st_d = RS_DISPATCHED;
					rs_qu_d = cur_q;
					state_d = S_OUT;
				end
			end
			S_CMP2: begin
				wsum = {1'b0, c_svc} + {1'b0, dur_q};
				sum_d = wsum[TIME_BITS] ? TIME_MAX : wsum[TIME_BITS-1:0];
				state_d = S_CMP3;
			end
			S_CMP3: begin
				s_val = (sum_q < floor_q) ? floor_q : sum_q;
				svc_d[cur_q] = s_val;
				last_d[cur_q] = now_t;
				if (s_val > maxs_q) maxs_d = s_val;
				fin_done_d = 1'b1;
				state_d = S_OVL;
			end
			S_OVL: begin
				// flag set: rescan every queue; flag clear: this queue alone
				ov_all_d = ovl_q;
				scan_d = '0;
				any_d = 1'b0;
				state_d = S_ORD;
			end
			S_ORD: state_d = S_OCK;
			S_OCK: begin
				if (!ov_all_q) begin
					ovl_d = o_hit;
					state_d = S_FIN;
				end else if (scan_q == QB'(NUM_QUEUES - 1)) begin
					ovl_d = any_q || o_hit;
					state_d = S_FIN;
				end else begin
					any_d = any_q || o_hit;
					scan_d = scan_q + 1'b1;
					state_d = S_ORD;
				end
			end
			S_FIN: begin
				rs_qu_d = cur_q;
				if (fin_done_q && c_cnt != '0) begin
					qst_d[cur_q] = QS_RUNNABLE;
				end else begin
					for (int i = 0; i < NUM_QUEUES; i++)
						if (qst_q[i] == QS_IDLE) iord_d[i] = iord_q[i] + 8'd1;
					iord_d[cur_q] = '0;
					qst_d[cur_q] = QS_IDLE;
				end
				if (fin_done_q) begin
					runv_d = 1'b0;
					rs_st_d = RS_COMPLETED;
				end else begin
					rs_st_d = RS_TRIM_EMPTY;
				end
				state_d = S_OUT;
			end
			S_OUT: begin
				res_valid = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		res.status        = rs_st_q;
		res.out_queue     = 4'(rs_qu_q);
		res.out_tag       = rs_tag_q;
		res.dropped_count = 5'(drop_q);
		res.overloaded    = ovl_q;
		res.pending_total = 9'(pend_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			for (int i = 0; i < NUM_QUEUES; i++) begin
				head_q[i] <= '0; cnt_q[i] <= '0; svc_q[i] <= '0;
				last_q[i] <= TIME_MAX; qst_q[i] <= QS_ABSENT;
				drp_q[i] <= 1'b0; iord_q[i] <= '0;
			end
			maxs_q <= '0; disp_q <= '0; floor_q <= '0;
			ovl_q <= 1'b0; runv_q <= 1'b0; runq_q <= '0; pend_q <= '0;
		end else begin
			state_q <= state_d;
			head_q <= head_d; cnt_q <= cnt_d; svc_q <= svc_d; last_q <= last_d;
			qst_q <= qst_d; drp_q <= drp_d; iord_q <= iord_d;
			maxs_q <= maxs_d; disp_q <= disp_d; floor_q <= floor_d;
			ovl_q <= ovl_d; runv_q <= runv_d; runq_q <= runq_d; pend_q <= pend_d;
		end
	end

	always_ff @(posedge clk) begin
		it_q <= it_d; scan_q <= scan_d; cur_q <= cur_d; ibest_q <= ibest_d;
		rbest_q <= rbest_d; iobest_q <= iobest_d; rsvc_q <= rsvc_d;
		dur_q <= dur_d; sum_q <= sum_d; ifound_q <= ifound_d; rfound_q <= rfound_d;
		ov_all_q <= ov_all_d; any_q <= any_d; fin_done_q <= fin_done_d;
		drop_q <= drop_d; rs_st_q <= rs_st_d; rs_qu_q <= rs_qu_d; rs_tag_q <= rs_tag_d;
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[waddr] <= wdata;
		rd_q <= mem[raddr];
	end

`ifndef NO_ASSERTIONS
	a_run_state: assert property (@(posedge clk) disable iff (!arst_n)
		runv_q |-> qst_q[runq_q] == QS_RUNNING)
		else $error("running queue not marked running");
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && item_valid && slot_free) |=> state_q == S_DEC)
		else $error("item taken but not decoded");
	a_slot: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> slot_free)
		else $error("result with output register occupied");
	a_pend: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= PB'(NUM_QUEUES * QUEUE_DEPTH))
		else $error("pending count out of range");
`endif

endmodule

// ----- rtl/fair_share_queue_scheduler_unit.sv -----
// ----------------------------------------------------------------------------
// fair_share_queue_scheduler_unit
// Least-attained-service scheduler over per-queue FIFOs of action tags.
// ----------------------------------------------------------------------------
//  channel  | signals                          | transfer when
//  ---------+----------------------------------+----------------------------
//  input    | in_valid, in_stall, in_data      | in_valid && !in_stall
//  output   | out_valid, out_stall, out_data   | out_valid && !out_stall
//  config   | cfg_wr_en, cfg_wr_data           | cfg_wr_en
//
//  The sequencer in fsqs_back takes one item at a time. Enqueue, busy
//    and no-pending pass decode and output; completion adds the service
//    update and overload check; dispatch adds the scan, a head read per
//    dropped entry, and the overload check when trimming empties the queue.
//  The entry memory has one read and one write port; the overload rescan
//  goes through it one queue per step; the queue scan steps over the queue state.
//  Reset is asynchronous, active low; no clearing pass, entries are written
//  before they can be read.
//  A two-deep input queue takes items while the sequencer works, until full;
//  the output register holds a result under out_stall.
// ----------------------------------------------------------------------------
module fair_share_queue_scheduler_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [47:0]         cfg_wr_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  fsqs_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output fsqs_pkg::out_item_t out_data
);
	import fsqs_pkg::*;

	logic [47:0] window_q;     // latency window register
	logic        item_valid, item_pop, slot_free, res_valid;
	in_item_t    item;
	out_item_t   res, out_q;
	logic        out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
		end else if (cfg_wr_en) begin
			window_q <= cfg_wr_data;
		end
	end

	fsqs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.item_valid (item_valid),
		.item_pop   (item_pop),
		.item       (item)
	);

	// sequencer starts an item only when its result has a place to go
	assign slot_free = !out_valid_q || !out_stall;

	fsqs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.window     (time_t'(window_q)),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop),
		.slot_free  (slot_free),
		.res_valid  (res_valid),
		.res        (res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) out_q <= res;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ----- bench/fsqs_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsqs_checker
// Watches both channels of the scheduler, predicts each result from the
// accepted items and compares the whole result against it.
// ----------------------------------------------------------------------------
module fsqs_checker
	import fsqs_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_wr_en,
	input  logic [47:0] cfg_wr_data,
	input  logic      in_valid,
	input  logic      in_stall,
	input  in_item_t  in_data,
	input  logic      out_valid,
	input  logic      out_stall,
	input  out_item_t out_data,
	output int        fail_count,
	output int        pending_results
);

	time_t      window;
	time_t      ent_time [NUM_QUEUES][QUEUE_DEPTH];
	logic [15:0] ent_tag [NUM_QUEUES][QUEUE_DEPTH];
	int         head [NUM_QUEUES];
	int         cnt [NUM_QUEUES];
	time_t      svc [NUM_QUEUES];
	time_t      served_at [NUM_QUEUES];
	logic [1:0] qstate [NUM_QUEUES];
	logic       drop_ok [NUM_QUEUES];
	int         idle_rank [NUM_QUEUES];
	int         idle_num;
	time_t      svc_max;
	logic       overload;
	int         run_q;
	logic       run_on;
	time_t      disp_at;
	time_t      svc_floor;
	int         total_pending;
	out_item_t  expected_results [$];

	assign pending_results = expected_results.size();

	function automatic time_t add_sat(time_t a, time_t b);
		logic [TIME_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TIME_BITS] ? TIME_MAX : s[TIME_BITS-1:0];
	endfunction

	function automatic logic head_stale(int q, time_t now);
		time_t t;
		if (cnt[q] == 0) return 1'b0;
		t = ent_time[q][head[q]];
		return now > t && (now - t) > window;
	endfunction

	function automatic void to_idle(int q);
		for (int i = 0; i < NUM_QUEUES; i++)
			if (qstate[i] == QS_IDLE) idle_rank[i]++;
		idle_rank[q] = 0;
		qstate[q] = QS_IDLE;
		idle_num++;
	endfunction

	function automatic void from_idle(int q);
		int r;
		r = idle_rank[q];
		for (int i = 0; i < NUM_QUEUES; i++)
			if (i != q && qstate[i] == QS_IDLE && idle_rank[i] > r) idle_rank[i]--;
		idle_rank[q] = 0;
		if (idle_num > 0) idle_num--;
	endfunction

	function automatic void pop(int q);
		head[q] = (head[q] + 1) % QUEUE_DEPTH;
		cnt[q]--;
		if (total_pending > 0) total_pending--;
	endfunction

	function automatic void recheck_overload(int q, time_t now);
		logic any;
		any = 1'b0;
		if (head_stale(q, now)) overload = 1'b1;
		else if (overload) begin
			for (int i = 0; i < NUM_QUEUES; i++)
				if (head_stale(i, now)) any = 1'b1;
			if (!any) overload = 1'b0;
		end
	endfunction

	function automatic out_item_t result(logic [2:0] st, int q, logic [15:0] tag, int dr);
		out_item_t r;
		r.status = st;
		r.out_queue = 4'(q);
		r.out_tag = tag;
		r.dropped_count = 5'(dr);
		r.overloaded = overload;
		r.pending_total = 9'(total_pending);
		return r;
	endfunction

	// one accepted item -> one expected result
	function automatic out_item_t schedule_item(in_item_t it);
		int q, best, dropped, slot;
		logic found;
		time_t now, dur, s;
		logic [15:0] tag;
		q = it.queue_id % NUM_QUEUES;
		now = it.now;
		dropped = 0;
		found = 1'b0;
		best = 0;
		case (it.mode)
			MODE_ENQ: begin
				if (cnt[q] >= QUEUE_DEPTH) return result(RS_FULL, q, 0, 0);
				if (qstate[q] == QS_ABSENT) begin
					qstate[q] = QS_RUNNABLE;
					drop_ok[q] = it.droppable;
					svc[q] = '0;
					served_at[q] = TIME_MAX;
					head[q] = 0;
					cnt[q] = 0;
				end else if (qstate[q] == QS_IDLE) begin
					from_idle(q);
					qstate[q] = QS_RUNNABLE;
				end
				slot = (head[q] + cnt[q]) % QUEUE_DEPTH;
				ent_time[q][slot] = now;
				ent_tag[q][slot] = it.action_tag;
				cnt[q]++;
				total_pending++;
				return result(RS_ENQUEUED, q, 0, 0);
			end
			MODE_DISP: begin
				if (run_on) return result(RS_BUSY, 0, 0, 0);
				// oldest idle queue is forgotten once stale
				for (int i = 0; i < NUM_QUEUES; i++)
					if (qstate[i] == QS_IDLE && (!found || idle_rank[i] > idle_rank[best])) begin
						best = i;
						found = 1'b1;
					end
				if (found && add_sat(served_at[best], window) < now) begin
					from_idle(best);
					qstate[best] = QS_ABSENT;
				end
				found = 1'b0;
				best = 0;
				for (int i = 0; i < NUM_QUEUES; i++)
					if (qstate[i] == QS_RUNNABLE && (!found || svc[i] < svc[best])) begin
						best = i;
						found = 1'b1;
					end
				if (!found) return result(RS_NONE_RUN, 0, 0, 0);
				q = best;
				while (drop_ok[q] && head_stale(q, now)) begin
					pop(q);
					dropped++;
				end
				if (cnt[q] == 0) begin
					recheck_overload(q, now);
					to_idle(q);
					return result(RS_TRIM_EMPTY, q, 0, dropped);
				end
				svc_floor = (svc_max > window) ? svc_max - window : '0;
				tag = ent_tag[q][head[q]];
				pop(q);
				qstate[q] = QS_RUNNING;
				run_q = q;
				run_on = 1'b1;
				disp_at = now;
				return result(RS_DISPATCHED, q, tag, dropped);
			end
			MODE_DONE: begin
				if (!run_on) return result(RS_NO_PEND, 0, 0, 0);
				q = run_q;
				dur = (now > disp_at) ? now - disp_at : '0;
				s = add_sat(svc[q], dur);
				if (s < svc_floor) s = svc_floor;
				svc[q] = s;
				served_at[q] = now;
				if (s > svc_max) svc_max = s;
				recheck_overload(q, now);
				if (cnt[q] == 0) to_idle(q);
				else qstate[q] = QS_RUNNABLE;
				run_on = 1'b0;
				return result(RS_COMPLETED, q, 0, 0);
			end
			default: return result(RS_NO_PEND, 0, 0, 0);
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t exp_r;
		if (!arst_n) begin
			window = WINDOW_RESET;
			for (int i = 0; i < NUM_QUEUES; i++) begin
				head[i] = 0;
				cnt[i] = 0;
				svc[i] = '0;
				served_at[i] = TIME_MAX;
				qstate[i] = QS_ABSENT;
				drop_ok[i] = 1'b0;
				idle_rank[i] = 0;
			end
			idle_num = 0;
			svc_max = '0;
			overload = 1'b0;
			run_q = 0;
			run_on = 1'b0;
			disp_at = '0;
			svc_floor = '0;
			total_pending = 0;
			fail_count = 0;
			expected_results.delete();
		end else begin
			if (cfg_wr_en) window = cfg_wr_data;
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result %p", out_data);
				end else begin
					exp_r = expected_results[0];
					expected_results.delete(0);
					if (out_data !== exp_r) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: expected %p got %p", exp_r, out_data);
					end
				end
			end
			if (in_valid && !in_stall)
				expected_results.push_back(schedule_item(in_data));
		end
	end

endmodule

// ----- bench/fair_share_queue_scheduler_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fair_share_queue_scheduler_unit_tb
// Drives directed and random enqueue / dispatch / completion traffic with
// random gaps and stalls across several window settings; the checker
// predicts and compares every result.
// ----------------------------------------------------------------------------
module fair_share_queue_scheduler_unit_tb;
	import fsqs_pkg::*;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      cfg_wr_en = 1'b0;
	logic [47:0] cfg_wr_data = '0;
	logic      in_valid = 1'b0;
	logic      in_stall;
	in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_item_t out_data;
	int        fail_count;
	int        pending_results;
	int        cycle_count = 0;
	int        stall_left = 0;
	int        stall_draw;
	logic [47:0] clock_now = '0; // scheduler time stamp, mostly forward
	logic      backlog_mode = 1'b0; // flag for a long-idle phase; never set in this bench

	always #4 clk = ~clk;

	fair_share_queue_scheduler_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	fsqs_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.fail_count(fail_count), .pending_results(pending_results)
	);

	// timeout: worst-case time per item (full trim, overload rescan,
	// gaps and stalls) over ~1730 items, times several
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 1000000) begin
			$display("fair_share_queue_scheduler_unit regression: fail");
			$finish;
		end
	end

	// receiver stalls: a stall of random length, possibly none, drawn after each result
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else if (out_valid && !out_stall) begin
			stall_draw = $urandom_range(0, 4);
			stall_left <= stall_draw;
			out_stall <= (stall_draw != 0);
		end else if (stall_left > 1) begin
			stall_left <= stall_left - 1;
		end else begin
			stall_left <= 0;
			out_stall <= 1'b0;
		end
	end

	// one transfer on the input channel, after a random gap when gaps is set; valid stays up
	// after the transfer until the next item or an explicit drain
	task automatic send_item(logic [1:0] mode, logic [3:0] qid, logic drop,
			logic [15:0] tag, logic [47:0] now, logic gaps);
		int gap;
		gap = gaps ? $urandom_range(0, 4) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{mode: mode, queue_id: qid, droppable: drop, action_tag: tag, now: now};
		do @(posedge clk); while (in_stall);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_window(logic [47:0] w);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= w;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// time step: usually small, sometimes a big jump, rarely backwards
	function automatic logic [47:0] next_now(logic [47:0] win);
		int pick;
		logic [47:0] step;
		pick = $urandom_range(0, 99);
		if (pick < 3) return clock_now - 48'($urandom_range(0, 50));
		if (pick < 8) step = 48'({$urandom, $urandom} % ({2'b0, win} * 3 + 2));
		else step = 48'($urandom_range(0, 40)) * (win / 64 + 1);
		return (clock_now > 48'hFFFF_0000_0000 - step) ? clock_now : clock_now + step;
	endfunction

	task automatic random_phase(int n, logic [47:0] win);
		int pick;
		logic [1:0] m;
		for (int k = 0; k < n; k++) begin
			pick = $urandom_range(0, 99);
			m = (pick < 45) ? MODE_ENQ : (pick < 72) ? MODE_DISP :
				(pick < 98) ? MODE_DONE : MODE_NOP;
			clock_now = next_now(win);
			send_item(m, 4'($urandom_range(0, 15)) & (pick[0] ? 4'hF : 4'h7),
				1'($urandom_range(0, 1)), 16'($urandom), clock_now, 1'b1);
			if (k == n / 2) begin
				// sender holds off until every result is back
				wait_drained();
			end
		end
	endtask

	logic [47:0] windows [5];

	initial begin
		windows = '{48'd1000000, 48'd0, 48'hFFFF_FFFF_FFFF, 48'd300, 48'd40};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset window, empty scheduler corner cases
		send_item(MODE_DONE, 0, 0, 0, 0, 0);
		send_item(MODE_DISP, 0, 0, 0, 0, 0);
		send_item(MODE_NOP, 4'hF, 1, 16'hFFFF, 48'hFFFF_FFFF_FFFF, 0);
		// fill queue 15 to full and overflow it, droppable
		for (int k = 0; k < 17; k++)
			send_item(MODE_ENQ, 4'hF, 1, 16'hFFFF - 16'(k), 48'(k), 0);
		send_item(MODE_ENQ, 4'h0, 0, 16'h0000, 48'd20, 0);
		// dispatch takes queue 0 on the service tie, then busy, then completion
		send_item(MODE_DISP, 0, 0, 0, 48'd5000000, 0);
		send_item(MODE_DISP, 0, 0, 0, 48'd5000001, 0);
		send_item(MODE_ENQ, 4'h0, 1, 16'h1234, 48'd5000002, 0);
		send_item(MODE_DONE, 0, 0, 0, 48'd4000000, 0);
		send_item(MODE_DISP, 0, 0, 0, 48'hFFFF_FFFF_FFFF, 0);
		send_item(MODE_DONE, 0, 0, 0, 48'hFFFF_FFFF_FFFF, 0);
		wait_drained();

		// sweep window settings with fresh random traffic
		for (int p = 0; p < 5; p++) begin
			write_window(windows[p]);
			clock_now = '0 + clock_now;
			random_phase(340, (windows[p] > 48'd5000000) ? 48'd5000000 : windows[p]);
			wait_drained();
		end
		write_window(48'($urandom));
		send_item(MODE_DISP, 0, 0, 0, 48'hFFFF_FFFF_FFFF, 1);
		send_item(MODE_DONE, 0, 0, 0, 48'hFFFF_FFFF_FFFF, 1);
		wait_drained();

		if (fail_count == 0) begin
			$display("fair_share_queue_scheduler_unit regression: pass");
		end else begin
			$display("fair_share_queue_scheduler_unit regression: fail");
		end
		$finish;
	end

endmodule
